// File: hw/rtl/blic_pkg.sv
// Shared types and constants for the battery LED indicator controller.
// Used by blic_want, blic_core and battery_led_indicator_fsm_unit.
`default_nettype none

package blic_pkg;

   typedef enum logic [6:0] {
      PAT_RED    = 7'b0000001,
      PAT_GREEN  = 7'b0000010,
      PAT_YELLOW = 7'b0000100,
      PAT_TR_ON  = 7'b0001000,
      PAT_TR_OFF = 7'b0010000,
      PAT_BREATH = 7'b0100000,
      PAT_OFF    = 7'b1000000
   } pat_type;

   localparam logic [2:0] CS_IDLE         = 3'd0;
   localparam logic [2:0] CS_DISCHARGING  = 3'd1;
   localparam logic [2:0] CS_IDLE0        = 3'd2;
   localparam logic [2:0] CS_BAD_COND     = 3'd3;
   localparam logic [2:0] CS_PRECHARGE    = 3'd4;
   localparam logic [2:0] CS_CHARGING     = 3'd5;
   localparam logic [2:0] CS_CHARGE_ERROR = 3'd6;

   localparam logic [1:0] SEL_RED    = 2'd0;
   localparam logic [1:0] SEL_GREEN  = 2'd1;
   localparam logic [1:0] SEL_YELLOW = 2'd2;
   localparam logic [1:0] SEL_RGB    = 2'd3;

   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;
   localparam logic [1:0] MODE_RUN  = 2'd2;

   localparam logic [1:0] PWR_NONE = 2'd0;
   localparam logic [1:0] PWR_ON   = 2'd1;
   localparam logic [1:0] PWR_OFF  = 2'd2;

   localparam logic OP_TICK = 1'b0;

   localparam logic [3:0] ENGINE_PC_PARKED = 4'd1;

   typedef struct packed {
      logic               op;
      logic               ext_power;
      logic [2:0]         charge_state;
      logic               battery_read_ok;
      logic signed [15:0] measured_current;
      logic signed [15:0] wanted_current;
      logic               engine_stepping;
      logic [3:0]         engine_pc;
      logic               host_auto;
      logic [7:0]         host_red;
      logic [7:0]         host_green;
      logic [7:0]         host_blue;
   } req_type;

   typedef struct packed {
      logic [1:0]  power_action;
      logic        load_program;
      logic        color_write;
      logic [1:0]  color_sel;
      logic [23:0] rgb_value;
      logic        pc_write;
      logic        engine_ctrl_write;
      logic [1:0]  engine_mode;
      logic        engine_sel_write;
      logic        third_channel_from_engine;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/blic_want.sv
// Desired LED pattern from charge state and battery currents.
// Depends on blic_pkg.
`default_nettype none

module blic_want
   import blic_pkg::*;
(
   input  wire req_type req,
   output pat_type      want
);

   logic cur_neg;
   logic want_pos;

   assign cur_neg  = req.measured_current < 16'sd0;
   assign want_pos = req.wanted_current > 16'sd0;

   always_comb begin
      case (req.charge_state)
         CS_IDLE:         want = PAT_GREEN;
         CS_DISCHARGING:  want = PAT_BREATH;
         CS_IDLE0,
         CS_BAD_COND,
         CS_PRECHARGE:    want = PAT_YELLOW;
         CS_CHARGING: begin
            if (!req.battery_read_ok) begin
               want = PAT_RED;
            end else if (cur_neg && want_pos) begin
               want = PAT_BREATH;
            end else if (req.measured_current != 16'sd0 && req.wanted_current != 16'sd0) begin
               want = PAT_YELLOW;
            end else begin
               want = PAT_GREEN;
            end
         end
         CS_CHARGE_ERROR: want = PAT_RED;
         default:         want = PAT_OFF;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/blic_core.sv
// Pattern state machine, power tracking and driver command bundle.
// Depends on blic_pkg and blic_want.
`default_nettype none

module blic_core
   import blic_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          fire,
   input  wire req_type req,
   output rsp_type      rsp
);

   pat_type pat_ff, pat_in;
   pat_type last_ff, last_in;
   logic    auto_ff, auto_in;
   logic    pknown_ff, pknown_in;
   logic    plevel_ff, plevel_in;

   pat_type want;
   pat_type color_next;
   logic    do_color;

   blic_want u_want (
      .req  (req),
      .want (want)
   );

   always_comb begin
      pat_in     = pat_ff;
      last_in    = last_ff;
      auto_in    = auto_ff;
      pknown_in  = pknown_ff;
      plevel_in  = plevel_ff;
      rsp        = '0;
      color_next = PAT_OFF;
      do_color   = 1'b0;

      if (req.op != OP_TICK) begin
         if (req.host_auto) begin
            if (!req.ext_power) begin
               rsp.power_action = PWR_OFF;
            end
            last_in = PAT_OFF;
            auto_in = 1'b1;
         end else begin
            auto_in = 1'b0;
            if (!req.ext_power) begin
               rsp.power_action = PWR_ON;
            end
            rsp.color_write = 1'b1;
            rsp.color_sel   = SEL_RGB;
            rsp.rgb_value   = {req.host_red, req.host_green, req.host_blue};
         end
      end else begin
         if (!pknown_ff || req.ext_power != plevel_ff) begin
            pknown_in = 1'b1;
            plevel_in = req.ext_power;
            if (req.ext_power) begin
               rsp.power_action = PWR_ON;
               rsp.load_program = 1'b1;
            end else begin
               rsp.power_action = PWR_OFF;
               pat_in           = PAT_OFF;
            end
         end
         if (req.ext_power) begin
            if (want == PAT_OFF) begin
               pat_in = PAT_OFF;
            end else begin
               case (pat_ff)
                  PAT_YELLOW: begin
                     if (want == PAT_BREATH) begin
                        pat_in                = PAT_TR_ON;
                        rsp.pc_write          = 1'b1;
                        rsp.engine_ctrl_write = 1'b1;
                        rsp.engine_mode       = MODE_STEP;
                     end else begin
                        pat_in     = want;
                        color_next = want;
                        do_color   = 1'b1;
                     end
                  end
                  PAT_BREATH: begin
                     if (want != PAT_BREATH) begin
                        pat_in                = PAT_TR_OFF;
                        rsp.engine_ctrl_write = 1'b1;
                        rsp.engine_mode       = MODE_STEP;
                     end
                  end
                  PAT_TR_ON: begin
                     rsp.engine_ctrl_write = 1'b1;
                     if (want == PAT_BREATH) begin
                        pat_in                        = PAT_BREATH;
                        rsp.engine_sel_write          = 1'b1;
                        rsp.third_channel_from_engine = 1'b1;
                        rsp.engine_mode               = MODE_RUN;
                     end else begin
                        pat_in          = PAT_YELLOW;
                        rsp.engine_mode = MODE_HOLD;
                     end
                  end
                  PAT_TR_OFF: begin
                     if (!req.engine_stepping) begin
                        if (req.engine_pc == ENGINE_PC_PARKED) begin
                           rsp.engine_ctrl_write = 1'b1;
                           rsp.engine_mode       = MODE_STEP;
                        end else begin
                           rsp.engine_sel_write = 1'b1;
                           rsp.color_write      = 1'b1;
                           rsp.color_sel        = SEL_YELLOW;
                           pat_in               = PAT_YELLOW;
                        end
                     end
                  end
                  default: begin
                     pat_in     = (want == PAT_BREATH) ? PAT_YELLOW : want;
                     color_next = pat_in;
                     do_color   = 1'b1;
                  end
               endcase
            end
         end
      end

      if (do_color && auto_ff && color_next != last_ff) begin
         case (color_next)
            PAT_RED: begin
               rsp.color_write = 1'b1;
               rsp.color_sel   = SEL_RED;
               last_in         = color_next;
            end
            PAT_GREEN: begin
               rsp.color_write = 1'b1;
               rsp.color_sel   = SEL_GREEN;
               last_in         = color_next;
            end
            PAT_YELLOW: begin
               rsp.color_write = 1'b1;
               rsp.color_sel   = SEL_YELLOW;
               last_in         = color_next;
            end
            default: begin
               last_in = last_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff    <= PAT_OFF;
         last_ff   <= PAT_OFF;
         auto_ff   <= 1'b1;
         pknown_ff <= 1'b0;
         plevel_ff <= 1'b0;
      end else if (fire) begin
         pat_ff    <= pat_in;
         last_ff   <= last_in;
         auto_ff   <= auto_in;
         pknown_ff <= pknown_in;
         plevel_ff <= plevel_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/battery_led_indicator_fsm_unit.sv
// Battery LED indicator controller, top level: input word register,
// state update and result word register. Depends on blic_pkg and blic_core.
//
// Each accepted word (a one-second tick or a host LED command) yields one
// result word of LED driver commands, which passes the input register and then
// the result register. The input register and the result register form a
// two-stage pipeline: one word is accepted per cycle while rsp_ready is high,
// and the result register lets a new word enter while a finished result still
// waits. The pattern state is updated as a word leaves the input register, so the next word sees it.
`default_nettype none

module battery_led_indicator_fsm_unit
   import blic_pkg::*;
(
   input  wire                clock,
   input  wire                reset,

   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_op,
   input  wire                req_ext_power,
   input  wire  [2:0]         req_charge_state,
   input  wire                req_battery_read_ok,
   input  wire  signed [15:0] req_measured_current,
   input  wire  signed [15:0] req_wanted_current,
   input  wire                req_engine_stepping,
   input  wire  [3:0]         req_engine_pc,
   input  wire                req_host_auto,
   input  wire  [7:0]         req_host_red,
   input  wire  [7:0]         req_host_green,
   input  wire  [7:0]         req_host_blue,

   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [1:0]         rsp_power_action,
   output logic               rsp_load_program,
   output logic               rsp_color_write,
   output logic [1:0]         rsp_color_sel,
   output logic [23:0]        rsp_rgb_value,
   output logic               rsp_pc_write,
   output logic               rsp_engine_ctrl_write,
   output logic [1:0]         rsp_engine_mode,
   output logic               rsp_engine_sel_write,
   output logic               rsp_third_channel_from_engine
);

   logic    in_valid_ff, in_valid_in;
   req_type req_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_next;
   logic    advance;
   logic    fire;
   logic    take;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = advance && in_valid_ff;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   blic_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff.op               <= req_op;
         req_ff.ext_power        <= req_ext_power;
         req_ff.charge_state     <= req_charge_state;
         req_ff.battery_read_ok  <= req_battery_read_ok;
         req_ff.measured_current <= req_measured_current;
         req_ff.wanted_current   <= req_wanted_current;
         req_ff.engine_stepping  <= req_engine_stepping;
         req_ff.engine_pc        <= req_engine_pc;
         req_ff.host_auto        <= req_host_auto;
         req_ff.host_red         <= req_host_red;
         req_ff.host_green       <= req_host_green;
         req_ff.host_blue        <= req_host_blue;
      end
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid                     = out_valid_ff;
   assign rsp_power_action              = rsp_ff.power_action;
   assign rsp_load_program              = rsp_ff.load_program;
   assign rsp_color_write               = rsp_ff.color_write;
   assign rsp_color_sel                 = rsp_ff.color_sel;
   assign rsp_rgb_value                 = rsp_ff.rgb_value;
   assign rsp_pc_write                  = rsp_ff.pc_write;
   assign rsp_engine_ctrl_write         = rsp_ff.engine_ctrl_write;
   assign rsp_engine_mode               = rsp_ff.engine_mode;
   assign rsp_engine_sel_write          = rsp_ff.engine_sel_write;
   assign rsp_third_channel_from_engine = rsp_ff.third_channel_from_engine;

endmodule

`default_nettype wire
